// File: design/plaarb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plaarb_pkg
// Types, codes and helpers shared by the power level arbiter modules.
// ----------------------------------------------------------------------------
package plaarb_pkg;

    typedef struct packed {
        logic [3:0]  mode;
        logic [3:0]  slot_id;
        logic [2:0]  level;
        logic [7:0]  priority_req;
        logic [15:0] millivolts;
        logic        charging;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] consumer_index;
        logic [3:0] old_level;
        logic [3:0] new_level;
        logic       status;
        logic       last_item;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  chain_length;
        logic [63:0] residency_steps_low;
        logic [63:0] residency_steps_high;
        logic        battery_policy_enabled;
        logic [15:0] lifeboat_below_millivolts;
        logic        charge_hold_en;
        logic [2:0]  charge_hold_level;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_ACTIVITY = 4'd1,
        OP_REQUEST  = 4'd2,
        OP_CREATE   = 4'd3,
        OP_ACQUIRE  = 4'd4,
        OP_RELEASE  = 4'd5,
        OP_ADD      = 4'd6,
        OP_REMOVE   = 4'd7,
        OP_BATTERY  = 4'd8,
        OP_CHARGE   = 4'd9,
        OP_BAD      = 4'd15
    } op_t;

    typedef struct packed {
        in_item_t item;
        op_t      op;
    } cmd_t;

    localparam logic [3:0] MODE_COUNT = 4'd10;

    localparam logic [1:0] KIND_SUSPEND = 2'd0;
    localparam logic [1:0] KIND_RESUME  = 2'd1;
    localparam logic [1:0] KIND_LEVEL   = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic [2:0] CFG_CHAIN_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_RES_LOW       = 3'd1;
    localparam logic [2:0] CFG_RES_HIGH      = 3'd2;
    localparam logic [2:0] CFG_BATT_POLICY   = 3'd3;
    localparam logic [2:0] CFG_LIFEBOAT_MV   = 3'd4;
    localparam logic [2:0] CFG_CHARGE_HOLDS  = 3'd5;
    localparam logic [2:0] CFG_CHARGE_LEVEL  = 3'd6;

    // items other than done that fit in front of the done item
    localparam logic [4:0] ITEM_CAP = 5'd17;

    // residency of one step in ticks, zero reads as one tick
    function automatic logic [15:0] residency(input logic [3:0] step,
                                              input logic [63:0] lo,
                                              input logic [63:0] hi);
        logic [63:0] w;
        logic [15:0] v;
        w = step[2] ? hi : lo;
        case (step[1:0])
            2'd0:    v = w[15:0];
            2'd1:    v = w[31:16];
            2'd2:    v = w[47:32];
            default: v = w[63:48];
        endcase
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

// File: design/power_level_arbiter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_level_arbiter_core
// Power level arbiter: idle decay, hold locks, battery override and ordered
// consumer suspend/resume over a descent chain of levels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one event request (valid/ready). m_* returns the result
//   items: zero or more suspend/resume items, a level change item when the
//   level moves, and always one done item with last_item set.
//   cfg_* writes a register by index; write only while the block is idle.
// Sequence:
//   An event passes the IDLE, EXEC and DONE states, with the ONE state added
//   for a suspend at add or a resume at remove. Each level recompute scans
//   all LOCK_SLOTS+1 lock slots for the lock floor, and when the level
//   changes, scans the consumer slots once per consumer acted on, plus once
//   more. One item is handled at a time by the back end; a two-entry queue
//   in front keeps accepting requests meanwhile.
// Reset: all locks and consumers invalid, level 0, decay disarmed.
// A stalled m_ready holds the back end at its next emission; the queue in
// front fills and then s_ready drops.
// ----------------------------------------------------------------------------
module power_level_arbiter_core import plaarb_pkg::*; #(
    parameter int CHAIN_MAX      = 8,
    parameter int LOCK_SLOTS     = 16,
    parameter int CONSUMER_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{chain_length: 4'd1, default: '0};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHAIN_LENGTH: cfg_reg.chain_length              <= cfg_data[3:0];
                CFG_RES_LOW:      cfg_reg.residency_steps_low       <= cfg_data;
                CFG_RES_HIGH:     cfg_reg.residency_steps_high      <= cfg_data;
                CFG_BATT_POLICY:  cfg_reg.battery_policy_enabled    <= cfg_data[0];
                CFG_LIFEBOAT_MV:  cfg_reg.lifeboat_below_millivolts <= cfg_data[15:0];
                CFG_CHARGE_HOLDS: cfg_reg.charge_hold_en            <= cfg_data[0];
                CFG_CHARGE_LEVEL: cfg_reg.charge_hold_level         <= cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    plaarb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    plaarb_back #(
        .CHAIN_MAX      (CHAIN_MAX),
        .LOCK_SLOTS     (LOCK_SLOTS),
        .CONSUMER_SLOTS (CONSUMER_SLOTS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: design/plaarb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plaarb_front
// Accepts event requests, decodes the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module plaarb_front import plaarb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_valid,
    output cmd_t     q_cmd,
    input  logic     q_pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd_in;
    logic       push;

    always_comb begin
        cmd_in.item = s_data;
        cmd_in.op   = (s_data.mode < MODE_COUNT) ? op_t'(s_data.mode) : OP_BAD;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: design/plaarb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plaarb_back
// Executes queued events: lock and consumer tables, idle decay, battery
// override, level arbitration and the ordered suspend/resume sequence.
// ----------------------------------------------------------------------------
module plaarb_back import plaarb_pkg::*; #(
    parameter int CHAIN_MAX      = 8,
    parameter int LOCK_SLOTS     = 16,
    parameter int CONSUMER_SLOTS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int LW = $clog2(LOCK_SLOTS + 1);
    localparam int CW = (CONSUMER_SLOTS > 1) ? $clog2(CONSUMER_SLOTS) : 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EXEC = 9'b000000010,
        S_ARB  = 9'b000000100,
        S_CMP  = 9'b000001000,
        S_SCAN = 9'b000010000,
        S_PICK = 9'b000100000,
        S_POST = 9'b001000000,
        S_ONE  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    in_item_t    item_reg, item_next;
    op_t         op_reg, op_next;
    logic [3:0]  cur_reg, cur_next;
    logic [3:0]  start_reg, start_next;
    logic [2:0]  idle_reg, idle_next;
    logic [15:0] rem_reg, rem_next;
    logic        armed_reg, armed_next;
    logic        ovr_reg, ovr_next;
    logic        chg_now_reg, chg_now_next;
    logic        held_reg, held_next;
    logic        bad_reg, bad_next;
    logic        second_reg, second_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [LW-1:0] lk_idx_reg, lk_idx_next;
    logic [CW-1:0] cn_idx_reg, cn_idx_next;
    logic [CW-1:0] pick_reg, pick_next;
    logic        found_reg, found_next;
    logic [7:0]  best_reg, best_next;
    logic [2:0]  fl_reg, fl_next;
    logic [3:0]  old_reg, old_next;
    logic [3:0]  new_reg, new_next;
    logic [1:0]  one_kind_reg, one_kind_next;

    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [LOCK_SLOTS:0] lk_valid_reg;
    logic [2:0]  lk_floor_reg [LOCK_SLOTS+1];
    logic [7:0]  lk_count_reg [LOCK_SLOTS+1];
    logic [CONSUMER_SLOTS-1:0] cn_valid_reg;
    logic [2:0]  cn_min_reg   [CONSUMER_SLOTS];
    logic [7:0]  cn_prio_reg  [CONSUMER_SLOTS];
    logic        cn_pw_reg    [CONSUMER_SLOTS];

    // table write controls
    logic        lk_valid_we, lk_floor_we, lk_count_we;
    logic [7:0]  lk_count_w;
    logic        cn_add, cn_rem, cn_pw_we, cn_pw_w;

    logic        load;
    out_item_t   load_data;
    logic        emit_ok, can_emit;
    logic [3:0]  eff_l;
    logic [3:0]  nw;
    logic [3:0]  arm_step;
    logic        rd_lk_valid;
    logic [2:0]  rd_lk_floor;
    logic [7:0]  rd_lk_count;
    logic        rd_cn_valid, rd_cn_pw;
    logic [2:0]  rd_cn_min;
    logic [7:0]  rd_cn_prio;
    logic        lk_slot_ok, cn_slot_ok;
    logic        lvl_bad;
    logic        suspend_dir, cand;

    always_comb begin
        if (cfg.chain_length == 4'd0) begin
            eff_l = 4'd1;
        end else if (cfg.chain_length > 4'(CHAIN_MAX)) begin
            eff_l = 4'(CHAIN_MAX);
        end else begin
            eff_l = cfg.chain_length;
        end
    end

    assign rd_lk_valid = lk_valid_reg[lk_idx_reg];
    assign rd_lk_floor = lk_floor_reg[lk_idx_reg];
    assign rd_lk_count = lk_count_reg[lk_idx_reg];
    assign rd_cn_valid = cn_valid_reg[cn_idx_reg];
    assign rd_cn_pw    = cn_pw_reg[cn_idx_reg];
    assign rd_cn_min   = cn_min_reg[cn_idx_reg];
    assign rd_cn_prio  = cn_prio_reg[cn_idx_reg];

    assign lk_slot_ok  = int'(item_reg.slot_id) < LOCK_SLOTS;
    assign cn_slot_ok  = int'(item_reg.slot_id) < CONSUMER_SLOTS;
    assign lvl_bad     = {1'b0, item_reg.level} >= eff_l;
    assign emit_ok     = !out_valid_reg || m_ready;
    assign can_emit    = cnt_reg < ITEM_CAP;
    assign suspend_dir = new_reg > old_reg;

    always_comb begin
        if (ovr_reg) begin
            nw = eff_l;
        end else begin
            nw = {1'b0, (idle_reg < fl_reg) ? idle_reg : fl_reg};
        end
    end

    always_comb begin
        if (suspend_dir) begin
            cand = rd_cn_valid && rd_cn_pw && (new_reg > {1'b0, rd_cn_min}) &&
                   (!found_reg || rd_cn_prio > best_reg);
        end else begin
            cand = rd_cn_valid && !rd_cn_pw && (new_reg <= {1'b0, rd_cn_min}) &&
                   (!found_reg || rd_cn_prio < best_reg);
        end
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        op_next       = op_reg;
        cur_next      = cur_reg;
        start_next    = start_reg;
        idle_next     = idle_reg;
        rem_next      = rem_reg;
        armed_next    = armed_reg;
        ovr_next      = ovr_reg;
        chg_now_next  = chg_now_reg;
        held_next     = held_reg;
        bad_next      = bad_reg;
        second_next   = second_reg;
        cnt_next      = cnt_reg;
        lk_idx_next   = lk_idx_reg;
        cn_idx_next   = cn_idx_reg;
        pick_next     = pick_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        fl_next       = fl_reg;
        old_next      = old_reg;
        new_next      = new_reg;
        one_kind_next = one_kind_reg;
        q_pop         = 1'b0;
        load          = 1'b0;
        load_data     = '0;
        lk_valid_we   = 1'b0;
        lk_floor_we   = 1'b0;
        lk_count_we   = 1'b0;
        lk_count_w    = rd_lk_count;
        cn_add        = 1'b0;
        cn_rem        = 1'b0;
        cn_pw_we      = 1'b0;
        cn_pw_w       = 1'b0;
        arm_step      = 4'd0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    item_next   = q_cmd.item;
                    op_next     = q_cmd.op;
                    start_next  = cur_reg;
                    bad_next    = 1'b0;
                    second_next = 1'b0;
                    cnt_next    = 5'd0;
                    lk_idx_next = (q_cmd.op == OP_CHARGE) ? LW'(LOCK_SLOTS)
                                                          : LW'(q_cmd.item.slot_id);
                    cn_idx_next = CW'(q_cmd.item.slot_id);
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (op_reg)
                    OP_TICK: begin
                        if (armed_reg) begin
                            if (rem_reg > 16'd1) begin
                                rem_next = rem_reg - 16'd1;
                            end else begin
                                rem_next   = 16'd0;
                                armed_next = 1'b0;
                                if ({1'b0, idle_reg} < eff_l - 4'd1) begin
                                    idle_next = idle_reg + 3'd1;
                                    // decay re-arm does not depend on the recompute
                                    arm_step  = {1'b0, idle_reg} + 4'd2;
                                    if (arm_step < eff_l) begin
                                        rem_next   = residency(arm_step,
                                                               cfg.residency_steps_low,
                                                               cfg.residency_steps_high);
                                        armed_next = 1'b1;
                                    end
                                    state_next = S_ARB;
                                end
                            end
                        end
                    end
                    OP_ACTIVITY: begin
                        idle_next  = 3'd0;
                        armed_next = 1'b0;
                        arm_step   = 4'd1;
                        if (arm_step < eff_l) begin
                            rem_next   = residency(arm_step, cfg.residency_steps_low,
                                                   cfg.residency_steps_high);
                            armed_next = 1'b1;
                        end
                        state_next = S_ARB;
                    end
                    OP_REQUEST: begin
                        if (lvl_bad) begin
                            bad_next = 1'b1;
                        end else begin
                            armed_next = 1'b0;
                            idle_next  = item_reg.level;
                            state_next = S_ARB;
                        end
                    end
                    OP_CREATE: begin
                        if (!lk_slot_ok || rd_lk_valid || lvl_bad) begin
                            bad_next = 1'b1;
                        end else begin
                            lk_valid_we = 1'b1;
                            lk_floor_we = 1'b1;
                            lk_count_we = 1'b1;
                            lk_count_w  = 8'd0;
                        end
                    end
                    OP_ACQUIRE: begin
                        if (!lk_slot_ok || !rd_lk_valid) begin
                            bad_next = 1'b1;
                        end else begin
                            lk_count_we = 1'b1;
                            lk_count_w  = (rd_lk_count == 8'hff) ? rd_lk_count
                                                                 : rd_lk_count + 8'd1;
                            state_next  = S_ARB;
                        end
                    end
                    OP_RELEASE: begin
                        if (!lk_slot_ok || !rd_lk_valid) begin
                            bad_next = 1'b1;
                        end else begin
                            lk_count_we = 1'b1;
                            lk_count_w  = (rd_lk_count == 8'd0) ? rd_lk_count
                                                                : rd_lk_count - 8'd1;
                            state_next  = S_ARB;
                        end
                    end
                    OP_ADD: begin
                        if (!cn_slot_ok || rd_cn_valid || lvl_bad) begin
                            bad_next = 1'b1;
                        end else begin
                            cn_add = 1'b1;
                            if (cur_reg > {1'b0, item_reg.level}) begin
                                one_kind_next = KIND_SUSPEND;
                                state_next    = S_ONE;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (!cn_slot_ok || !rd_cn_valid) begin
                            bad_next = 1'b1;
                        end else begin
                            cn_rem = 1'b1;
                            if (!rd_cn_pw) begin
                                one_kind_next = KIND_RESUME;
                                state_next    = S_ONE;
                            end
                        end
                    end
                    OP_BATTERY: begin
                        if (cfg.battery_policy_enabled &&
                            cfg.lifeboat_below_millivolts != 16'd0) begin
                            if (chg_now_reg) begin
                                if (ovr_reg) begin
                                    ovr_next   = 1'b0;
                                    state_next = S_ARB;
                                end
                            end else if (item_reg.millivolts != 16'd0) begin
                                if ((item_reg.millivolts < cfg.lifeboat_below_millivolts)
                                    != ovr_reg) begin
                                    ovr_next   = !ovr_reg;
                                    state_next = S_ARB;
                                end
                            end
                        end
                    end
                    OP_CHARGE: begin
                        if (cfg.battery_policy_enabled &&
                            item_reg.charging != chg_now_reg) begin
                            chg_now_next = item_reg.charging;
                            second_next  = item_reg.charging && ovr_reg;
                            if (cfg.charge_hold_en && item_reg.charging &&
                                !held_reg && {1'b0, cfg.charge_hold_level} < eff_l) begin
                                lk_valid_we = 1'b1;
                                lk_floor_we = 1'b1;
                                lk_count_we = 1'b1;
                                lk_count_w  = 8'd1;
                                held_next   = 1'b1;
                                state_next  = S_ARB;
                            end else if (cfg.charge_hold_en &&
                                         !item_reg.charging && held_reg) begin
                                lk_count_we = 1'b1;
                                lk_count_w  = 8'd0;
                                held_next   = 1'b0;
                                state_next  = S_ARB;
                            end else if (item_reg.charging && ovr_reg) begin
                                second_next = 1'b0;
                                ovr_next    = 1'b0;
                                state_next  = S_ARB;
                            end
                        end
                    end
                    default: begin
                        bad_next = 1'b1;
                    end
                endcase
                if (state_next == S_ARB) begin
                    lk_idx_next = '0;
                    fl_next     = 3'(eff_l - 4'd1);
                end
            end
            S_ARB: begin
                if (rd_lk_valid && rd_lk_count != 8'd0 && rd_lk_floor < fl_reg) begin
                    fl_next = rd_lk_floor;
                end
                if (lk_idx_reg == LW'(LOCK_SLOTS)) begin
                    state_next = S_CMP;
                end else begin
                    lk_idx_next = lk_idx_reg + 1'b1;
                end
            end
            S_CMP: begin
                if (nw == cur_reg) begin
                    state_next = S_POST;
                end else begin
                    cur_next    = nw;
                    old_next    = cur_reg;
                    new_next    = nw;
                    cn_idx_next = '0;
                    found_next  = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cand) begin
                    found_next = 1'b1;
                    best_next  = rd_cn_prio;
                    pick_next  = cn_idx_reg;
                end
                if (cn_idx_reg == CW'(CONSUMER_SLOTS - 1)) begin
                    state_next = S_PICK;
                end else begin
                    cn_idx_next = cn_idx_reg + 1'b1;
                end
            end
            S_PICK: begin
                if (!can_emit || emit_ok) begin
                    if (can_emit) begin
                        load     = 1'b1;
                        cnt_next = cnt_reg + 5'd1;
                    end
                    load_data.old_level = old_reg;
                    load_data.new_level = new_reg;
                    if (found_reg) begin
                        cn_pw_we    = 1'b1;
                        cn_pw_w     = !suspend_dir;
                        load_data.kind           = suspend_dir ? KIND_SUSPEND : KIND_RESUME;
                        load_data.consumer_index = 4'(pick_reg);
                        cn_idx_next = '0;
                        found_next  = 1'b0;
                        state_next  = S_SCAN;
                    end else begin
                        load_data.kind = KIND_LEVEL;
                        state_next     = S_POST;
                    end
                end
            end
            S_POST: begin
                if (second_reg) begin
                    second_next = 1'b0;
                    ovr_next    = 1'b0;
                    lk_idx_next = '0;
                    fl_next     = 3'(eff_l - 4'd1);
                    state_next  = S_ARB;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_ONE: begin
                if (!can_emit || emit_ok) begin
                    load                     = can_emit;
                    load_data.kind           = one_kind_reg;
                    load_data.consumer_index = item_reg.slot_id;
                    load_data.old_level      = cur_reg;
                    load_data.new_level      = cur_reg;
                    cnt_next                 = can_emit ? cnt_reg + 5'd1 : cnt_reg;
                    state_next               = S_DONE;
                end
            end
            S_DONE: begin
                if (emit_ok) begin
                    load                = 1'b1;
                    load_data.kind      = KIND_DONE;
                    load_data.old_level = start_reg;
                    load_data.new_level = cur_reg;
                    load_data.status    = bad_reg;
                    load_data.last_item = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_reg       <= 4'd0;
            idle_reg      <= 3'd0;
            rem_reg       <= 16'd1;
            armed_reg     <= 1'b0;
            ovr_reg       <= 1'b0;
            chg_now_reg   <= 1'b0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            lk_valid_reg  <= '0;
            cn_valid_reg  <= '0;
            for (int i = 0; i <= LOCK_SLOTS; i++) begin
                lk_count_reg[i] <= 8'd0;
            end
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            idle_reg      <= idle_next;
            rem_reg       <= rem_next;
            armed_reg     <= armed_next;
            ovr_reg       <= ovr_next;
            chg_now_reg   <= chg_now_next;
            held_reg      <= held_next;
            out_valid_reg <= (out_valid_reg && !m_ready) || load;
            if (lk_valid_we) begin
                lk_valid_reg[lk_idx_reg] <= 1'b1;
            end
            if (lk_count_we) begin
                lk_count_reg[lk_idx_reg] <= lk_count_w;
            end
            if (cn_add) begin
                cn_valid_reg[cn_idx_reg] <= 1'b1;
            end else if (cn_rem) begin
                cn_valid_reg[cn_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        op_reg        <= op_next;
        start_reg     <= start_next;
        bad_reg       <= bad_next;
        second_reg    <= second_next;
        cnt_reg       <= cnt_next;
        lk_idx_reg    <= lk_idx_next;
        cn_idx_reg    <= cn_idx_next;
        pick_reg      <= pick_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        fl_reg        <= fl_next;
        old_reg       <= old_next;
        new_reg       <= new_next;
        one_kind_reg  <= one_kind_next;
        if (load) begin
            out_reg <= load_data;
        end
        if (lk_floor_we) begin
            lk_floor_reg[lk_idx_reg] <= (op_reg == OP_CHARGE) ? cfg.charge_hold_level
                                                             : item_reg.level;
        end
        if (cn_add) begin
            cn_min_reg[cn_idx_reg]  <= item_reg.level;
            cn_prio_reg[cn_idx_reg] <= item_reg.priority_req;
            cn_pw_reg[cn_idx_reg]   <= cur_reg <= {1'b0, item_reg.level};
        end else if (cn_pw_we) begin
            cn_pw_reg[pick_reg] <= cn_pw_w;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped outside idle");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.last_item |-> out_reg.kind == KIND_DONE)
        else $error("last item is not a done item");

    a_charge_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg |-> lk_valid_reg[LOCK_SLOTS] && lk_count_reg[LOCK_SLOTS] == 8'd1)
        else $error("charge lock flag out of step with its slot");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= 4'(CHAIN_MAX))
        else $error("effective level beyond chain range");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for power_level_arbiter_core: directed and random power
// events, an in-bench level arbiter predicts every suspend/resume/level/done
// result, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
    import plaarb_pkg::*;

    localparam int NLOCK = 16;
    localparam int NCONS = 16;
    localparam int CYCLE_LIMIT = 3000000;

    class level_tracker;
        // registers
        logic [3:0]  len_cfg;
        logic [63:0] res_lo, res_hi;
        logic        batt_en, hold_en;
        logic [15:0] lifeboat_mv;
        logic [2:0]  hold_lvl;
        // arbiter state
        int unsigned cur_lvl, idle_tgt, decay_left;
        bit          decay_on, override_on, charging_now, chg_lock_held;
        bit          lk_valid[NLOCK+1];
        int unsigned lk_floor[NLOCK+1];
        int unsigned lk_count[NLOCK+1];
        bit          cn_valid[NCONS];
        int unsigned cn_min[NCONS];
        int unsigned cn_prio[NCONS];
        bit          cn_powered[NCONS];
        out_item_t   step_items[$];
        out_item_t   due_items[$];
        int          mismatches;

        function new();
            len_cfg = 4'd1; res_lo = '0; res_hi = '0; batt_en = 0; hold_en = 0;
            lifeboat_mv = '0; hold_lvl = '0;
            cur_lvl = 0; idle_tgt = 0; decay_left = 1; decay_on = 0;
            override_on = 0; charging_now = 0; chg_lock_held = 0;
            foreach (lk_valid[i]) begin
                lk_valid[i] = 0; lk_floor[i] = 0; lk_count[i] = 0;
            end
            foreach (cn_valid[i]) begin
                cn_valid[i] = 0; cn_min[i] = 0; cn_prio[i] = 0; cn_powered[i] = 0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                CFG_CHAIN_LENGTH: len_cfg     = d[3:0];
                CFG_RES_LOW:      res_lo      = d;
                CFG_RES_HIGH:     res_hi      = d;
                CFG_BATT_POLICY:  batt_en     = d[0];
                CFG_LIFEBOAT_MV:  lifeboat_mv = d[15:0];
                CFG_CHARGE_HOLDS: hold_en     = d[0];
                CFG_CHARGE_LEVEL: hold_lvl    = d[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned levels();
            if (len_cfg < 1) return 1;
            if (len_cfg > 8) return 8;
            return len_cfg;
        endfunction

        function int unsigned dwell(int unsigned step);
            logic [63:0] w;
            logic [15:0] v;
            w = (step[2]) ? res_hi : res_lo;
            v = 16'(w >> (16 * step[1:0]));
            return (v == 0) ? 1 : v;
        endfunction

        function void push(logic [1:0] k, int unsigned idx, int unsigned o, int unsigned n,
                           bit st, bit last);
            out_item_t r;
            r.kind = k; r.consumer_index = idx[3:0]; r.old_level = o[3:0];
            r.new_level = n[3:0]; r.status = st; r.last_item = last;
            step_items.push_back(r);
        endfunction

        function int unsigned target_level();
            int unsigned fl, t;
            fl = levels() - 1;
            if (override_on) return levels();
            for (int i = 0; i <= NLOCK; i++)
                if (lk_valid[i] && lk_count[i] > 0 && lk_floor[i] < fl) fl = lk_floor[i];
            t = idle_tgt;
            if (fl < t) t = fl;
            return t;
        endfunction

        function void relevel();
            int unsigned nw, od;
            int pick, best;
            nw = target_level();
            od = cur_lvl;
            if (nw == od) return;
            cur_lvl = nw;
            forever begin
                pick = -1;
                if (nw > od) begin
                    best = -1;
                    for (int i = 0; i < NCONS; i++)
                        if (cn_valid[i] && cn_powered[i] && nw > cn_min[i] &&
                            int'(cn_prio[i]) > best) begin
                            best = cn_prio[i]; pick = i;
                        end
                end else begin
                    best = 32'h7fffffff;
                    for (int i = 0; i < NCONS; i++)
                        if (cn_valid[i] && !cn_powered[i] && nw <= cn_min[i] &&
                            int'(cn_prio[i]) < best) begin
                            best = cn_prio[i]; pick = i;
                        end
                end
                if (pick < 0) break;
                cn_powered[pick] = (nw < od);
                push((nw > od) ? KIND_SUSPEND : KIND_RESUME, pick, od, nw, 0, 0);
            end
            push(KIND_LEVEL, 0, od, nw, 0, 0);
        endfunction

        function void rearm();
            if (idle_tgt + 1 >= levels()) begin
                decay_on = 0;
                return;
            end
            decay_left = dwell(idle_tgt + 1);
            decay_on = 1;
        endfunction

        function void take_event(in_item_t e);
            int unsigned nl, start, s, lv;
            bit bad, low;
            nl = levels(); start = cur_lvl; bad = 0;
            s = e.slot_id; lv = e.level;
            step_items.delete();
            case (e.mode)
                OP_TICK: if (decay_on) begin
                    if (decay_left > 1) decay_left--;
                    else begin
                        decay_left = 0; decay_on = 0;
                        if (idle_tgt < nl - 1) begin
                            idle_tgt++; relevel(); rearm();
                        end
                    end
                end
                OP_ACTIVITY: begin
                    idle_tgt = 0; decay_on = 0; relevel(); rearm();
                end
                OP_REQUEST: begin
                    if (lv >= nl) bad = 1;
                    else begin
                        decay_on = 0; idle_tgt = lv; relevel();
                    end
                end
                OP_CREATE: begin
                    if (s >= NLOCK || lk_valid[s] || lv >= nl) bad = 1;
                    else begin
                        lk_valid[s] = 1; lk_floor[s] = lv; lk_count[s] = 0;
                    end
                end
                OP_ACQUIRE: begin
                    if (s >= NLOCK || !lk_valid[s]) bad = 1;
                    else begin
                        if (lk_count[s] < 255) lk_count[s]++;
                        relevel();
                    end
                end
                OP_RELEASE: begin
                    if (s >= NLOCK || !lk_valid[s]) bad = 1;
                    else begin
                        if (lk_count[s] > 0) lk_count[s]--;
                        relevel();
                    end
                end
                OP_ADD: begin
                    if (s >= NCONS || cn_valid[s] || lv >= nl) bad = 1;
                    else begin
                        cn_valid[s] = 1; cn_min[s] = lv; cn_prio[s] = e.priority_req;
                        cn_powered[s] = (cur_lvl <= lv);
                        if (!cn_powered[s]) push(KIND_SUSPEND, s, cur_lvl, cur_lvl, 0, 0);
                    end
                end
                OP_REMOVE: begin
                    if (s >= NCONS || !cn_valid[s]) bad = 1;
                    else begin
                        cn_valid[s] = 0;
                        if (!cn_powered[s]) push(KIND_RESUME, s, cur_lvl, cur_lvl, 0, 0);
                    end
                end
                OP_BATTERY: if (batt_en && lifeboat_mv != 0) begin
                    if (charging_now) begin
                        if (override_on) begin
                            override_on = 0; relevel();
                        end
                    end else if (e.millivolts != 0) begin
                        low = e.millivolts < lifeboat_mv;
                        if (low != override_on) begin
                            override_on = low; relevel();
                        end
                    end
                end
                OP_CHARGE: if (batt_en && e.charging != charging_now) begin
                    charging_now = e.charging;
                    if (hold_en) begin
                        if (e.charging && !chg_lock_held && hold_lvl < nl) begin
                            lk_valid[NLOCK] = 1; lk_floor[NLOCK] = hold_lvl;
                            lk_count[NLOCK] = 1; chg_lock_held = 1; relevel();
                        end else if (!e.charging && chg_lock_held) begin
                            lk_count[NLOCK] = 0; chg_lock_held = 0; relevel();
                        end
                    end
                    if (e.charging && override_on) begin
                        override_on = 0; relevel();
                    end
                end
                default: bad = 1;
            endcase
            // done item always fits: at most ITEM_CAP items ahead of it
            while (step_items.size() > ITEM_CAP) void'(step_items.pop_back());
            push(KIND_DONE, 0, start, cur_lvl, bad, 1);
            foreach (step_items[i]) due_items.push_back(step_items[i]);
        endfunction

        function void match_result(out_item_t got);
            out_item_t want;
            if (due_items.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = due_items.pop_front();
            if (got.kind != want.kind || got.consumer_index != want.consumer_index ||
                got.old_level != want.old_level || got.new_level != want.new_level ||
                got.status != want.status || got.last_item != want.last_item) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_item_t   m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    level_tracker tracker = new();
    bit      no_idle = 0;
    bit      hold_long = 0;
    longint  cycles = 0;

    power_level_arbiter_core dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) tracker.match_result(m_data);

    // result side: random stalls, plus one long hold-off on request
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_long) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                hold_long = 0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    task automatic send_event(in_item_t e);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_event(e);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (tracker.due_items.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, d);
    endtask

    task automatic setup(logic [3:0] len, logic [63:0] lo, logic [63:0] hi, bit batt,
                         logic [15:0] mv, bit holds, logic [2:0] hl);
        write_reg(CFG_CHAIN_LENGTH, 64'(len));
        write_reg(CFG_RES_LOW, lo);
        write_reg(CFG_RES_HIGH, hi);
        write_reg(CFG_BATT_POLICY, 64'(batt));
        write_reg(CFG_LIFEBOAT_MV, 64'(mv));
        write_reg(CFG_CHARGE_HOLDS, 64'(holds));
        write_reg(CFG_CHARGE_LEVEL, 64'(hl));
        cfg_valid <= 0;
    endtask

    function automatic in_item_t make_event(op_t op, int slot, int lvl, int prio,
                                            int mv, bit chg);
        in_item_t e;
        e.mode = op; e.slot_id = 4'(slot); e.level = 3'(lvl);
        e.priority_req = 8'(prio); e.millivolts = 16'(mv); e.charging = chg;
        return e;
    endfunction

    function automatic in_item_t random_event();
        in_item_t e;
        int r;
        e = '0;
        e.slot_id      = 4'($urandom);
        e.level        = 3'($urandom);
        e.priority_req = 8'($urandom);
        e.millivolts   = 16'($urandom);
        e.charging     = 1'($urandom);
        r = $urandom_range(0, 99);
        // narrow slots most of the time so requests hit live locks/consumers
        if ($urandom_range(0, 3) != 0) e.slot_id = 4'($urandom_range(0, 5));
        if (r < 30)      e.mode = OP_TICK;
        else if (r < 37) e.mode = OP_ACTIVITY;
        else if (r < 45) e.mode = OP_REQUEST;
        else if (r < 54) e.mode = OP_CREATE;
        else if (r < 65) e.mode = OP_ACQUIRE;
        else if (r < 74) e.mode = OP_RELEASE;
        else if (r < 82) e.mode = OP_ADD;
        else if (r < 88) e.mode = OP_REMOVE;
        else if (r < 93) e.mode = OP_BATTERY;
        else if (r < 98) e.mode = OP_CHARGE;
        else             e.mode = 4'($urandom_range(MODE_COUNT, 15));
        if (e.mode == OP_BATTERY && $urandom_range(0, 1))
            e.millivolts = 16'($urandom_range(0, 4000));
        return e;
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        setup(4'd8, 64'h0002_0001_0003_0000, 64'h0001_0002_0001_0002, 1, 16'd3300, 1, 3'd2);

        send_event(make_event(OP_ACTIVITY, 0, 0, 0, 0, 0));
        send_event(make_event(OP_CREATE, 0, 2, 0, 0, 0));
        send_event(make_event(OP_CREATE, 0, 1, 0, 0, 0));
        send_event(make_event(OP_CREATE, 15, 7, 0, 0, 0));
        send_event(make_event(OP_ACQUIRE, 3, 0, 0, 0, 0));
        send_event(make_event(OP_ADD, 0, 1, 255, 0, 0));
        send_event(make_event(OP_ADD, 1, 3, 255, 0, 0));
        send_event(make_event(OP_ADD, 15, 0, 0, 0, 0));
        send_event(make_event(OP_ADD, 2, 7, 8'h55, 0, 1));
        send_event(make_event(OP_REQUEST, 0, 7, 0, 16'hffff, 0));
        send_event(make_event(OP_ACQUIRE, 0, 0, 0, 0, 0));
        send_event(make_event(OP_RELEASE, 0, 0, 0, 0, 0));
        send_event(make_event(OP_RELEASE, 0, 0, 0, 0, 0));
        send_event(make_event(OP_REQUEST, 0, 0, 0, 0, 0));
        repeat (5) send_event(make_event(OP_TICK, 0, 0, 0, 0, 0));
        send_event(make_event(OP_BATTERY, 0, 0, 0, 1000, 0));
        send_event(make_event(OP_BATTERY, 0, 0, 0, 0, 0));
        send_event(make_event(OP_CHARGE, 0, 0, 0, 0, 1));
        send_event(make_event(OP_BATTERY, 0, 0, 0, 65535, 1));
        send_event(make_event(OP_CHARGE, 0, 0, 0, 0, 0));
        send_event(make_event(OP_REMOVE, 15, 0, 0, 0, 0));
        send_event(make_event(OP_BAD, 0, 0, 0, 0, 0));
        send_event(make_event(op_t'(MODE_COUNT), 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: setup(4'd0, '0, '0, 0, 16'd0, 0, 3'd0);
                1: setup(4'd15, 64'h0001_0001_0001_0001, '1, 1, 16'hffff, 1, 3'd7);
                2: setup(4'd5, {4{16'h0002}}, {4{16'h0001}}, 1, 16'd2000, 1, 3'd1);
                default: setup(4'd3, '0, 64'h8000_0000_0000_0000, 1, 16'd1500, 0, 3'd4);
            endcase
            for (int n = 0; n < 52; n++) begin
                if (ph == 2 && n == 10) hold_long = 1;
                if (ph == 3 && n == 20) drain();
                if (ph == 3 && n == 36) no_idle = 1;
                send_event(random_event());
            end
        end

        s_valid <= 0;
        while (tracker.due_items.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
